FILE: rtl/mteq_pkg.sv
// Package for the timer expiry queue: operation and status codes, widths.
// No dependencies.
package mteq_pkg;
  localparam int unsigned NumTimersDef = 32;
  localparam int unsigned NumQueuesDef = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PayW = 32;
  localparam int unsigned DestW = 4;
  localparam int unsigned HandleW = 5;

  typedef enum logic [2:0] {
    OpAlloc = 3'd0, OpFree = 3'd1, OpInit = 3'd2, OpSetTime = 3'd3, OpTick = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StNoFree = 2'd1, StBadHandle = 2'd2, StBusy = 2'd3
  } status_e;

  localparam logic [1:0] SlotFree = 2'd0;
  localparam logic [1:0] SlotAlloc = 2'd1;
  localparam logic [1:0] SlotRun = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [HandleW-1:0] handle;
    logic               expired;
    logic [PayW-1:0]    payload;
    logic [DestW-1:0]   dest;
    logic               last;
  } result_t;
endpackage

FILE: rtl/mteq_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module mteq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/multi_timer_expiry_queue.sv
// Timer expiry queue top level: sequencer, slot states and list walk.
// Depends on mteq_pkg and mteq_ram.
// Alloc scans one slot per cycle and answers once a free slot is found or the scan ends;
// free and init answer in the cycle after accept; settime walks the due-ordered list with
// a RAM read then a compare per entry; a tick that expires nothing only advances the count,
// otherwise each expired timer passes through STickRd, STickEmit, STickPeek and STickLast.
// One transaction is worked at a time; s_axis_tready is low until results are taken.
// Reset (rst_ni low, async): all slots free, list empty, tick count zero, earliest all ones.
module multi_timer_expiry_queue
  import mteq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDef,
  parameter int unsigned NUM_QUEUES = NumQueuesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tuser: operation[2:0]
  input  logic [2:0]   s_axis_tuser,
  // tdata: handle[4:0], delay[36:5], payload[68:37], dest_queue[72:69]
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tuser: expired[0]
  output logic         m_axis_tuser,
  // tdata: status[1:0], handle_out[6:2], payload_out[38:7], dest_out[42:39]
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast
);
  localparam int unsigned IdxW = $clog2(NUM_TIMERS);
  localparam int unsigned LinkW = IdxW + 1;
  localparam logic [LinkW-1:0] EndMark = LinkW'(NUM_TIMERS);

  // sequencer states
  localparam logic [3:0] SIdle = 4'd0, SAlloc = 4'd1, SInsRd = 4'd2, SInsCmp = 4'd3,
                         SInsLink = 4'd4, STickRd = 4'd5, STickEmit = 4'd6,
                         SOut = 4'd7, SHeadRd = 4'd8, SHeadSet = 4'd9,
                         STickPeek = 4'd10, STickLast = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] slot_q [NUM_TIMERS];

  // input transaction fields
  logic [2:0]       in_op;
  logic [HandleW-1:0] in_h;
  logic [TimeW-1:0] in_delay;
  logic [PayW-1:0]  in_pay;
  logic [DestW-1:0] in_dq;
  assign in_op    = s_axis_tuser;
  assign in_h     = s_axis_tdata[4:0];
  assign in_delay = s_axis_tdata[36:5];
  assign in_pay   = s_axis_tdata[68:37];
  assign in_dq    = s_axis_tdata[72:69];

  logic [LinkW-1:0] head_q;
  logic [TimeW-1:0] tick_q, early_q;
  logic [IdxW-1:0]  h_q;        // slot being armed
  logic [TimeW-1:0] due_q;      // its due time
  logic [LinkW-1:0] prev_q, cur_q;
  logic [IdxW:0]    scan_q;     // alloc scan / emit count
  logic [LinkW-1:0] guard_q;
  result_t          res_q;
  logic             out_v_q;

  // RAMs: due time, payload+dest, link. One shared read address.
  logic             due_we, pd_we, lk_we;
  logic [IdxW-1:0]  due_wa, pd_wa, lk_wa, rd_a;
  logic [TimeW-1:0] due_wd, due_rd;
  logic [PayW+DestW-1:0] pd_wd, pd_rd;
  logic [LinkW-1:0] lk_wd, lk_rd;

  mteq_ram #(.Width(TimeW), .Depth(NUM_TIMERS)) u_due (
    .clk_i, .we_i(due_we), .waddr_i(due_wa), .wdata_i(due_wd),
    .raddr_i(rd_a), .rdata_o(due_rd));
  mteq_ram #(.Width(PayW + DestW), .Depth(NUM_TIMERS)) u_pd (
    .clk_i, .we_i(pd_we), .waddr_i(pd_wa), .wdata_i(pd_wd),
    .raddr_i(rd_a), .rdata_o(pd_rd));
  mteq_ram #(.Width(LinkW), .Depth(NUM_TIMERS)) u_lk (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd),
    .raddr_i(rd_a), .rdata_o(lk_rd));

  assign s_axis_tready = (state_q == SIdle) && !out_v_q;
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = res_q.expired;
  assign m_axis_tdata  = {5'd0, res_q.dest, res_q.payload, res_q.handle, res_q.status};

  logic [TimeW-1:0] tick_inc;
  assign tick_inc = tick_q + 1'b1;

  // shared unsigned compare: earliest due vs next count, due to insert vs list entry,
  // or list entry vs count
  logic [TimeW-1:0] cmp_a, cmp_b;
  logic             cmp_gt;
  assign cmp_gt = cmp_a > cmp_b;
  always_comb begin
    cmp_a = due_q;
    cmp_b = due_rd;
    if (state_q == STickEmit || state_q == STickLast) begin
      cmp_a = due_rd;
      cmp_b = tick_q;
    end else if (state_q == SIdle) begin
      cmp_a = early_q;
      cmp_b = tick_inc;
    end
  end

  logic in_range;
  assign in_range = {1'b0, in_h} < (HandleW + 1)'(NUM_TIMERS);
  logic [IdxW-1:0] in_hi;
  assign in_hi = in_h[IdxW-1:0];
  logic cur_ok;
  assign cur_ok = cur_q < EndMark;
  // walk ends here: list end, result cap, or next entry not yet due
  logic tick_stop;
  assign tick_stop = !cur_ok || scan_q == (IdxW + 1)'(NUM_TIMERS) || cmp_gt;

  // register next values
  logic [LinkW-1:0] head_d, prev_d, cur_d, guard_d;
  logic [TimeW-1:0] tick_d, early_d, due_d;
  logic [IdxW-1:0]  h_d;
  logic [IdxW:0]    scan_d;
  result_t          res_d;
  logic             out_v_d;
  logic             sl_we;
  logic [IdxW-1:0]  sl_a;
  logic [1:0]       sl_v;

  always_comb begin
    state_d = state_q; head_d = head_q; tick_d = tick_q; early_d = early_q;
    h_d = h_q; due_d = due_q; prev_d = prev_q; cur_d = cur_q; scan_d = scan_q;
    guard_d = guard_q; res_d = res_q; out_v_d = out_v_q;
    sl_we = 1'b0; sl_a = h_q; sl_v = SlotFree;
    due_we = 1'b0; due_wa = h_q; due_wd = due_q;
    pd_we = 1'b0; pd_wa = in_hi; pd_wd = {in_pay, in_dq};
    lk_we = 1'b0; lk_wa = h_q; lk_wd = cur_q;
    rd_a = cur_q[IdxW-1:0];
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          res_d = '0;
          res_d.handle = in_h;
          res_d.last = 1'b1;
          h_d = in_hi;
          case (in_op)
            OpAlloc: begin
              scan_d = '0;
              state_d = SAlloc;
            end
            OpFree, OpInit, OpSetTime: begin
              out_v_d = 1'b1;
              if (!in_range || slot_q[in_hi] == SlotFree) begin
                res_d.status = StBadHandle;
              end else if (in_op == OpFree) begin
                if (slot_q[in_hi] == SlotRun) res_d.status = StBusy;
                else begin
                  sl_we = 1'b1; sl_a = in_hi; sl_v = SlotFree;
                end
              end else if (in_op == OpInit) begin
                if ({{(9-DestW){1'b0}}, in_dq} >= 9'(NUM_QUEUES)) res_d.status = StBadHandle;
                else pd_we = 1'b1;
              end else if (slot_q[in_hi] == SlotRun) begin
                res_d.status = StBusy;
              end else begin
                out_v_d = 1'b0;   // result given once linked
                due_d = tick_q + in_delay;
                sl_we = 1'b1; sl_a = in_hi; sl_v = SlotRun;
                prev_d = EndMark; cur_d = head_q; guard_d = '0;
                state_d = SInsRd;
              end
            end
            OpTick: begin
              tick_d = tick_inc;
              if (!cmp_gt) begin
                cur_d = head_q; scan_d = '0;
                state_d = STickRd;
              end
            end
            default: ;
          endcase
        end
      end
      SAlloc: begin
        if (slot_q[scan_q[IdxW-1:0]] == SlotFree) begin
          sl_we = 1'b1; sl_a = scan_q[IdxW-1:0]; sl_v = SlotAlloc;
          res_d.handle = HandleW'(scan_q);
          out_v_d = 1'b1; state_d = SIdle;
        end else if (scan_q == (IdxW + 1)'(NUM_TIMERS - 1)) begin
          res_d.status = StNoFree; res_d.handle = '0;
          out_v_d = 1'b1; state_d = SIdle;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      SInsRd: begin
        due_we = 1'b1;   // store due time while walking
        if (cur_ok && guard_q < EndMark) state_d = SInsCmp;
        else state_d = SInsLink;
      end
      SInsCmp: begin
        if (cmp_gt) begin
          prev_d = cur_q; cur_d = lk_rd; guard_d = guard_q + 1'b1;
          state_d = SInsRd;
        end else state_d = SInsLink;
      end
      SInsLink: begin
        lk_we = 1'b1; lk_wa = h_q; lk_wd = cur_ok ? cur_q : EndMark;
        if (prev_q >= EndMark) begin
          head_d = {1'b0, h_q}; early_d = due_q;
        end
        state_d = SOut;
      end
      SOut: begin
        if (prev_q < EndMark) begin
          lk_we = 1'b1; lk_wa = prev_q[IdxW-1:0]; lk_wd = {1'b0, h_q};
        end
        out_v_d = 1'b1; state_d = SIdle;
      end
      STickRd: begin
        if (!out_v_q || m_axis_tready) begin
          if (cur_ok && scan_q < (IdxW + 1)'(NUM_TIMERS)) state_d = STickEmit;
          else begin
            head_d = cur_ok ? cur_q : EndMark;
            state_d = SHeadRd;
          end
        end
      end
      STickEmit: begin
        // build the result, but hold it until the next entry is checked
        if (!cmp_gt) begin
          sl_we = 1'b1; sl_a = cur_q[IdxW-1:0]; sl_v = SlotAlloc;
          res_d = '0;
          res_d.handle = HandleW'(cur_q);
          res_d.expired = 1'b1;
          res_d.payload = pd_rd[PayW+DestW-1:DestW];
          res_d.dest = pd_rd[DestW-1:0];
          scan_d = scan_q + 1'b1; cur_d = lk_rd;
          state_d = STickPeek;
        end else begin
          head_d = cur_q;
          state_d = SHeadRd;
        end
      end
      STickPeek: begin
        // read the next entry's due time
        state_d = STickLast;
      end
      STickLast: begin
        res_d.last = tick_stop;
        out_v_d = 1'b1;
        if (tick_stop) begin
          head_d = cur_ok ? cur_q : EndMark;
          early_d = cur_ok ? due_rd : '1;
          state_d = SIdle;
        end else state_d = STickRd;
      end
      SHeadRd: begin
        rd_a = head_q[IdxW-1:0];
        state_d = SHeadSet;
      end
      SHeadSet: begin
        early_d = (head_q < EndMark) ? due_rd : '1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; head_q <= EndMark; tick_q <= '0; early_q <= '1;
      out_v_q <= 1'b0; scan_q <= '0; guard_q <= '0; prev_q <= EndMark; cur_q <= EndMark;
      for (int i = 0; i < NUM_TIMERS; i++) slot_q[i] <= SlotFree;
    end else begin
      state_q <= state_d; head_q <= head_d; tick_q <= tick_d; early_q <= early_d;
      out_v_q <= out_v_d; scan_q <= scan_d; guard_q <= guard_d;
      prev_q <= prev_d; cur_q <= cur_d;
      if (sl_we) slot_q[sl_a] <= sl_v;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; due_q <= due_d; res_q <= res_d;
  end
endmodule

FILE: rtl/mteq_checker.sv
// Port-level checker for the timer expiry queue, bound to the top level.
// Depends on nothing else.
module mteq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tuser,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("output changed while held");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting during result");
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast) else $error("last missing");
  a_expiry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == 2'd0)
    else $error("expiry status");
endmodule

bind multi_timer_expiry_queue mteq_checker u_mteq_checker (.*);
